### hdl/npc_pkg.sv
// npc_pkg: shared types, constants and the palette ROM image for nearest_palette_color.
// No dependencies; used by npc_cell and nearest_palette_color.
package npc_pkg;

  // Chain geometry
  localparam int CELL_COUNT = 8;
  localparam int CELL_BITS  = 3;
  localparam int IDX_BITS   = 8;
  localparam int PASS_BITS  = IDX_BITS - CELL_BITS;
  localparam int DIST_BITS  = 18;
  localparam int ROM_DEPTH  = 254;
  localparam int ROM_SLOTS  = 256;

  typedef logic [23:0] rgb_t;
  typedef rgb_t palette_t [ROM_SLOTS];

  // 16 ANSI colours
  localparam rgb_t ANSI_COLORS [16] = '{
    24'h000000, 24'hcd0000, 24'h00cd00, 24'hcdcd00,
    24'h0000ee, 24'hcd00cd, 24'h00cdcd, 24'he5e5e5,
    24'h7f7f7f, 24'hff0000, 24'h00ff00, 24'hffff00,
    24'h5c5cff, 24'hff00ff, 24'h00ffff, 24'hffffff
  };

  // Levels of the 6x6x6 colour cube
  localparam logic [7:0] CUBE_LEVELS [6] = '{
    8'h00, 8'h5f, 8'h87, 8'haf, 8'hd7, 8'hff
  };

  // ROM image: ANSI colours, cube (red slowest), grey ramp, zero beyond depth
  function automatic palette_t build_palette();
    palette_t   p;
    int         n;
    logic [7:0] grey;
    for (int i = 0; i < ROM_SLOTS; i++) begin
      p[i] = '0;
    end
    for (int i = 0; i < 16; i++) begin
      p[i] = ANSI_COLORS[i];
    end
    n = 16;
    for (int r = 0; r < 6; r++) begin
      for (int g = 0; g < 6; g++) begin
        for (int b = 0; b < 6; b++) begin
          p[n] = {CUBE_LEVELS[r], CUBE_LEVELS[g], CUBE_LEVELS[b]};
          n++;
        end
      end
    end
    for (int k = 0; k < 22; k++) begin
      grey = (k == 0) ? 8'd0 : 8'(8 + 10 * k);
      p[232 + k] = {grey, grey, grey};
    end
    return p;
  endfunction

  localparam palette_t PALETTE = build_palette();

  // Request travelling along the chain with its running best
  typedef struct packed {
    logic                 valid;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [PASS_BITS-1:0] pass;
    logic [IDX_BITS-1:0]  best_idx;
    logic [DIST_BITS-1:0] best_dist;
    logic                 pend_valid;
    logic [IDX_BITS-1:0]  pend_idx;
    logic [DIST_BITS-1:0] pend_dist;
    logic                 fin;
  } tok_t;

  // Finished result from a cell
  typedef struct packed {
    logic                 done;
    logic [IDX_BITS-1:0]  idx;
    logic [DIST_BITS-1:0] sq_dist;
  } res_t;

  // Squared difference of two 8-bit channel values
  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d * d);
  endfunction

endpackage

### hdl/nearest_palette_color.sv
// Nearest palette colour search: one request (an 8-bit RGB pixel) is taken while busy is low
// and start is high. With min(PALETTE_ENTRIES, 254) entries searched, the index of the first
// closest palette entry and its squared distance appear for exactly one cycle with out_valid;
// the receiver cannot hold a result off. The pixel walks a ring of eight cells, one palette
// entry per cycle, so the entry count sets the time per request: busy drops in the cycle the
// result shows, and a new request is taken only once the last one is through.
// Uses npc_pkg and npc_cell.
module nearest_palette_color #(
  parameter int PALETTE_ENTRIES = 254
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  output logic                           out_valid,
  output logic [npc_pkg::IDX_BITS-1:0]   out_palette_index,
  output logic [npc_pkg::DIST_BITS-1:0]  out_least_distance
);

  localparam int LIMIT = (PALETTE_ENTRIES > npc_pkg::ROM_DEPTH) ?
                         npc_pkg::ROM_DEPTH : PALETTE_ENTRIES;
  localparam logic [npc_pkg::IDX_BITS-1:0] LAST_IDX = npc_pkg::IDX_BITS'(LIMIT - 1);

  npc_pkg::tok_t                   head_tok;
  npc_pkg::tok_t                   tok_link [npc_pkg::CELL_COUNT];
  npc_pkg::res_t                   res_link [npc_pkg::CELL_COUNT];
  logic [npc_pkg::CELL_COUNT-1:0]  tok_vld;
  logic [npc_pkg::CELL_COUNT-1:0]  done_vec;
  logic                            accept;
  logic                            done_any;
  logic [npc_pkg::IDX_BITS-1:0]    done_idx;
  logic [npc_pkg::DIST_BITS-1:0]   done_dist;
  logic                            busy_r, busy_nxt;
  logic                            out_valid_r;
  logic [npc_pkg::IDX_BITS-1:0]    out_idx_r;
  logic [npc_pkg::DIST_BITS-1:0]   out_dist_r;

  assign accept = start && !busy_r;

  // Head of the ring: a fresh request when idle, else the request coming round
  always_comb begin
    if (busy_r) begin
      head_tok = tok_link[npc_pkg::CELL_COUNT-1];
    end else begin
      head_tok            = '0;
      head_tok.valid      = start;
      head_tok.red        = in_red;
      head_tok.green      = in_green;
      head_tok.blue       = in_blue;
      head_tok.best_dist  = '1;
      head_tok.pend_valid = 1'b0;
    end
  end

  // Ring of cells
  for (genvar c = 0; c < npc_pkg::CELL_COUNT; c++) begin : g_cell
    npc_cell #(
      .CELL_ID  (c),
      .LAST_IDX (LAST_IDX)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  ((c == 0) ? head_tok : tok_link[(c == 0) ? 0 : c - 1]),
      .tok_out (tok_link[c]),
      .res_out (res_link[c])
    );
    assign tok_vld[c]  = tok_link[c].valid;
    assign done_vec[c] = res_link[c].done;
  end

  // Gather the result from whichever cell finished
  always_comb begin
    done_any  = 1'b0;
    done_idx  = '0;
    done_dist = '0;
    for (int c = 0; c < npc_pkg::CELL_COUNT; c++) begin
      if (res_link[c].done) begin
        done_any  = 1'b1;
        done_idx  = done_idx  | res_link[c].idx;
        done_dist = done_dist | res_link[c].sq_dist;
      end
    end
  end

  // Busy from accept until the result is registered
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (done_any) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= done_any;
      if (done_any) begin
        out_idx_r  <= done_idx;
        out_dist_r <= done_dist;
      end
    end
  end

  assign busy               = busy_r;
  assign out_valid          = out_valid_r;
  assign out_palette_index  = out_idx_r;
  assign out_least_distance = out_dist_r;

  // Checks
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tok_vld, done_vec}))
    else $error("more than one request in the ring");

  a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ((|tok_vld) || (|done_vec)))
    else $error("busy with no request in the ring");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("accepted request did not raise busy");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy_r))
    else $error("result without a request in flight");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_palette_index <= LAST_IDX))
    else $error("result index beyond searched entries");

endmodule

### hdl/npc_cell.sv
// npc_cell: one cell of the search chain; scores one palette entry per visit
// and folds the previous cell's score into the running best. Uses npc_pkg.
module npc_cell #(
  parameter int                            CELL_ID  = 0,
  parameter logic [npc_pkg::IDX_BITS-1:0]  LAST_IDX = 8'd253
) (
  input  logic          clk,
  input  logic          rst_n,
  input  npc_pkg::tok_t tok_in,
  output npc_pkg::tok_t tok_out,
  output npc_pkg::res_t res_out
);

  npc_pkg::tok_t                   tok_r, tok_nxt;
  npc_pkg::res_t                   res_r, res_nxt;
  logic [npc_pkg::IDX_BITS-1:0]    idx;
  npc_pkg::rgb_t                   entry;
  logic [npc_pkg::DIST_BITS-1:0]   entry_dist;
  logic                            take_pend;
  logic [npc_pkg::IDX_BITS-1:0]    merged_idx;
  logic [npc_pkg::DIST_BITS-1:0]   merged_dist;

  // Entry owned by this cell on the current pass
  assign idx   = {tok_in.pass, npc_pkg::CELL_BITS'(CELL_ID)};
  assign entry = npc_pkg::PALETTE[idx];
  assign entry_dist = npc_pkg::DIST_BITS'(npc_pkg::sq_diff(entry[23:16], tok_in.red))
                    + npc_pkg::DIST_BITS'(npc_pkg::sq_diff(entry[15:8],  tok_in.green))
                    + npc_pkg::DIST_BITS'(npc_pkg::sq_diff(entry[7:0],   tok_in.blue));

  // Strict compare: an earlier entry keeps a tie
  assign take_pend   = tok_in.pend_valid && (tok_in.pend_dist < tok_in.best_dist);
  assign merged_idx  = take_pend ? tok_in.pend_idx  : tok_in.best_idx;
  assign merged_dist = take_pend ? tok_in.pend_dist : tok_in.best_dist;

  always_comb begin
    tok_nxt            = tok_in;
    tok_nxt.valid      = tok_in.valid && !tok_in.fin;
    tok_nxt.pass       = (CELL_ID == npc_pkg::CELL_COUNT - 1) ?
                         tok_in.pass + npc_pkg::PASS_BITS'(1) : tok_in.pass;
    tok_nxt.best_idx   = merged_idx;
    tok_nxt.best_dist  = merged_dist;
    tok_nxt.pend_valid = 1'b1;
    tok_nxt.pend_idx   = idx;
    tok_nxt.pend_dist  = entry_dist;
    tok_nxt.fin        = (idx == LAST_IDX);

    res_nxt.done    = tok_in.valid && tok_in.fin;
    res_nxt.idx     = merged_idx;
    res_nxt.sq_dist = merged_dist;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
      res_r.done  <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      res_r <= res_nxt;
    end
  end

  assign tok_out = tok_r;
  assign res_out = res_r;

endmodule
